FILE: design/assert_macros.svh
// Assertion macros used by the converter's top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);
// Implication checked in the following cycle.
`define ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);
`endif

FILE: design/fpfc_pkg.sv
// Package with types, codes and constants of the fixed-point format converter.
package fpfc_pkg;
    localparam int FRACTION_BITS = 8;

    typedef enum logic [1:0] {
        REQ_INT_TO_FIXED   = 2'd0,
        REQ_FLOAT_TO_FIXED = 2'd1,
        REQ_FIXED_TO_FLOAT = 2'd2,
        REQ_FIXED_TO_INT   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NAN   = 2'd1,
        ST_INF   = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    localparam logic signed [31:0] INT_MAX_OK = 32'sd8388607;
    localparam logic signed [31:0] INT_MIN_OK = -32'sd8388608;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] int_value;
        logic [31:0]        float_bits;
        logic signed [31:0] fixed_value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] fixed_result;
        logic [31:0]        float_result_bits;
        logic signed [23:0] int_result;
        logic [1:0]         status;
    } out_t;

    // Decoded operand handed from the front stage to the shift stage.
    typedef struct packed {
        req_type_t   req;
        status_t     status;
        logic        sign;
        logic [31:0] mag;
        logic [5:0]  shamt;
        logic        left;
        logic [5:0]  pos;
        logic [31:0] direct;
    } dec_t;

    // Shifted value with rounding bits, handed to the rounding stage.
    typedef struct packed {
        req_type_t   req;
        status_t     status;
        logic        sign;
        logic [31:0] shifted;
        logic        round_bit;
        logic        sticky;
        logic [5:0]  pos;
        logic [31:0] direct;
    } shf_t;
endpackage

FILE: design/fixed_point_format_converter.sv
// Top level of the Q24.8 fixed-point format converter with its pipeline registers.
//
// Channel  Direction  Payload
// s_       in         fpfc_pkg::in_t   request transaction
// m_       out        fpfc_pkg::out_t  result transaction
//
// One transaction can enter every cycle unless a stall at m_ready backs up into
// the first stage. Decode, shift and round each end in a register, so a result
// is offered once its request has passed dec_reg, shf_reg and out_reg.
// Synchronous active-low reset clears only the stage valid bits.
// m_ready low holds a full stage only if all later ones are full; empty stages fill.
module fixed_point_format_converter (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  fpfc_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output fpfc_pkg::out_t m_data
);
    import fpfc_pkg::*;
    `include "assert_macros.svh"

    dec_t dec_next, dec_reg;
    shf_t shf_next, shf_reg;
    out_t out_next, out_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    fpfc_decode u_decode (.in_item(s_data), .dec(dec_next));
    fpfc_shift  u_shift  (.dec(dec_reg),    .shf(shf_next));
    fpfc_round  u_round  (.shf(shf_reg),    .res(out_next));

    assign en3 = !v3_reg || m_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v3_reg;
    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
        if (en1) dec_reg <= dec_next;
        if (en2) shf_reg <= shf_next;
        if (en3) out_reg <= out_next;
    end

    `ASSERT_NEXT(a_out_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `ASSERT_IMPLIES(a_ready_when_empty, aclk, aresetn, !v1_reg, s_ready, "not ready with empty first stage")
    `ASSERT_IMPLIES(a_err_zero, aclk, aresetn, m_valid && m_data.status != ST_OK, m_data.fixed_result == 32'd0, "error result not zero")
endmodule

FILE: design/fpfc_decode.sv
// Front stage: classifies the request and finds the float conversions' shift.
module fpfc_decode (
    input  fpfc_pkg::in_t  in_item,
    output fpfc_pkg::dec_t dec
);
    import fpfc_pkg::*;

    logic [7:0]  ex;
    logic [22:0] fr;
    logic [23:0] sig;
    logic [31:0] fmag;
    logic [5:0]  p;
    logic signed [9:0] k;
    logic [31:0] n_mag;
    logic [31:0] u;

    always_comb begin
        ex = in_item.float_bits[30:23];
        fr = in_item.float_bits[22:0];
        sig = (ex != 8'd0) ? {1'b1, fr} : {1'b0, fr};
        u = in_item.fixed_value;
        n_mag = u[31] ? (32'd0 - u) : u;
        p = 6'd0;
        for (int i = 0; i < 32; i++) begin
            if (n_mag[i]) p = 6'(i);
        end
        fmag = 32'd0;
        k = '0;
        dec = '0;
        dec.req = req_type_t'(in_item.req_type);
        dec.status = ST_OK;
        case (req_type_t'(in_item.req_type))
            REQ_INT_TO_FIXED: begin
                if (in_item.int_value > INT_MAX_OK || in_item.int_value < INT_MIN_OK) begin
                    dec.status = ST_RANGE;
                end else begin
                    dec.direct = 32'(in_item.int_value <<< FRACTION_BITS);
                end
            end
            REQ_FLOAT_TO_FIXED: begin
                dec.sign = in_item.float_bits[31];
                fmag = {8'd0, sig};
                k = (ex != 8'd0) ? (10'(ex) - 10'sd150 + 10'(FRACTION_BITS))
                                 : (-10'sd149 + 10'(FRACTION_BITS));
                dec.mag = fmag;
                if (k >= 0) begin
                    dec.left = 1'b1;
                    dec.shamt = 6'(k);
                end else begin
                    dec.left = 1'b0;
                    dec.shamt = (k < -10'sd26) ? 6'd26 : 6'(-k);
                end
                if (ex == 8'hFF) begin
                    dec.status = (fr != 23'd0) ? ST_NAN : ST_INF;
                end else if (ex >= 8'd151) begin
                    dec.status = ST_RANGE;
                end else if (ex >= 8'd150) begin
                    // Integral value from 2^23 up to 2^24 - 1.
                    if (!(in_item.float_bits[31] && sig == 24'h800000)) dec.status = ST_RANGE;
                end else if (ex == 8'd149 && sig == 24'hFFFFFF) begin
                    // 8388607.5 is beyond the positive bound.
                    if (!in_item.float_bits[31]) dec.status = ST_RANGE;
                end
                if (ex == 8'd149 && sig == 24'hFFFFFF && in_item.float_bits[31]) begin
                    dec.status = ST_OK;
                end
            end
            REQ_FIXED_TO_FLOAT: begin
                dec.sign = u[31];
                dec.mag = n_mag;
                dec.pos = p;
                if (p <= 6'd23) begin
                    dec.left = 1'b1;
                    dec.shamt = 6'd23 - p;
                end else begin
                    dec.left = 1'b0;
                    dec.shamt = p - 6'd23;
                end
            end
            REQ_FIXED_TO_INT: begin
                dec.direct = 32'(in_item.fixed_value >>> FRACTION_BITS);
            end
            default: dec.status = ST_OK;
        endcase
    end
endmodule

FILE: design/fpfc_shift.sv
// Middle stage: aligns the magnitude and gathers the rounding bits.
module fpfc_shift (
    input  fpfc_pkg::dec_t dec,
    output fpfc_pkg::shf_t shf
);
    import fpfc_pkg::*;

    logic [63:0] wide;
    logic [63:0] mask;

    always_comb begin
        shf = '0;
        shf.req = dec.req;
        shf.status = dec.status;
        shf.sign = dec.sign;
        shf.pos = dec.pos;
        shf.direct = dec.direct;
        wide = 64'd0;
        mask = 64'd0;
        if (dec.left) begin
            shf.shifted = dec.mag << dec.shamt;
        end else begin
            wide = {dec.mag, 32'd0} >> dec.shamt;
            shf.shifted = wide[63:32];
            shf.round_bit = wide[31];
            mask = {33'd0, {31{1'b1}}};
            shf.sticky = |(wide & mask);
        end
    end
endmodule

FILE: design/fpfc_round.sv
// Last stage: rounds, packs the float and forms the result transaction.
module fpfc_round (
    input  fpfc_pkg::shf_t shf,
    output fpfc_pkg::out_t res
);
    import fpfc_pkg::*;

    logic [32:0] q;
    logic [24:0] mant;
    logic [7:0]  expo;

    always_comb begin
        res = '0;
        q = {1'b0, shf.shifted} + {32'd0, shf.round_bit};
        mant = {1'b0, shf.shifted[23:0]};
        if (shf.round_bit && (shf.sticky || shf.shifted[0])) mant = mant + 25'd1;
        expo = 8'(shf.pos) - 8'(FRACTION_BITS) + 8'd127;
        if (mant[24]) begin
            mant = mant >> 1;
            expo = expo + 8'd1;
        end
        res.status = shf.status;
        case (shf.req)
            REQ_INT_TO_FIXED: begin
                if (shf.status == ST_OK) res.fixed_result = shf.direct;
            end
            REQ_FLOAT_TO_FIXED: begin
                if (shf.status == ST_OK) begin
                    res.fixed_result = shf.sign ? (32'd0 - q[31:0]) : q[31:0];
                end
            end
            REQ_FIXED_TO_FLOAT: begin
                if (shf.shifted != 32'd0) res.float_result_bits = {shf.sign, expo, mant[22:0]};
            end
            REQ_FIXED_TO_INT: res.int_result = shf.direct[23:0];
            default: res = '0;
        endcase
    end
endmodule

FILE: tb/fixed_point_format_converter_tb.sv
// Testbench for the Q24.8 fixed-point format converter with a self-checking scoreboard.
`timescale 1ns / 100ps

class conversion_scoreboard;
    fpfc_pkg::out_t pending_results[$];
    int unsigned    mismatches;
    int unsigned    unexpected;

    function fpfc_pkg::out_t convert(fpfc_pkg::in_t req);
        fpfc_pkg::out_t res;
        logic [31:0] bits, mag, mant, rem, half, u;
        logic [7:0]  ex;
        logic [23:0] sig;
        int          e, k, s, p, sh;
        logic [31:0] whole;
        logic        fracnz;
        logic [63:0] q;
        res = '0;
        case (fpfc_pkg::req_type_t'(req.req_type))
            fpfc_pkg::REQ_INT_TO_FIXED: begin
                if (req.int_value > fpfc_pkg::INT_MAX_OK || req.int_value < fpfc_pkg::INT_MIN_OK)
                    res.status = fpfc_pkg::ST_RANGE;
                else
                    res.fixed_result = req.int_value <<< fpfc_pkg::FRACTION_BITS;
            end
            fpfc_pkg::REQ_FLOAT_TO_FIXED: begin
                bits = req.float_bits;
                ex = bits[30:23];
                if (ex == 8'hFF) begin
                    res.status = (bits[22:0] != 0) ? fpfc_pkg::ST_NAN : fpfc_pkg::ST_INF;
                end else if (ex >= 8'd151) begin
                    res.status = fpfc_pkg::ST_RANGE;
                end else begin
                    sig = (ex != 0) ? {1'b1, bits[22:0]} : {1'b0, bits[22:0]};
                    e = (ex != 0) ? int'(ex) - 150 : -149;
                    if (-e >= 32) begin
                        whole = 0;
                        fracnz = sig != 0;
                    end else begin
                        whole = 32'(sig) >> (-e);
                        fracnz = (32'(sig) & ((32'd1 << (-e)) - 1)) != 0;
                    end
                    if ((!bits[31] && (whole > 8388607 || (whole == 8388607 && fracnz))) ||
                        (bits[31] && (whole > 8388608 || (whole == 8388608 && fracnz)))) begin
                        res.status = fpfc_pkg::ST_RANGE;
                    end else begin
                        k = e + fpfc_pkg::FRACTION_BITS;
                        if (k >= 0) begin
                            q = 64'(sig) << k;
                        end else begin
                            s = -k;
                            if (s > 25) begin
                                q = 0;
                            end else begin
                                rem = 32'(sig) & ((32'd1 << s) - 1);
                                q = 64'(sig) >> s;
                                if (rem >= (32'd1 << (s - 1)))
                                    q++;
                            end
                        end
                        if (bits[31])
                            q = -q;
                        res.fixed_result = q[31:0];
                    end
                end
            end
            fpfc_pkg::REQ_FIXED_TO_FLOAT: begin
                u = req.fixed_value;
                mag = u[31] ? -u : u;
                if (mag != 0) begin
                    p = 31;
                    while (!mag[p])
                        p--;
                    if (p <= 23) begin
                        mant = mag << (23 - p);
                    end else begin
                        sh = p - 23;
                        rem = mag & ((32'd1 << sh) - 1);
                        half = 32'd1 << (sh - 1);
                        mant = mag >> sh;
                        if (rem > half || (rem == half && mant[0]))
                            mant++;
                        if (mant == 32'h100_0000) begin
                            mant = mant >> 1;
                            p++;
                        end
                    end
                    res.float_result_bits = {u[31], 8'(p - fpfc_pkg::FRACTION_BITS + 127),
                                             mant[22:0]};
                end
            end
            default: begin
                res.int_result = 24'(req.fixed_value >>> fpfc_pkg::FRACTION_BITS);
            end
        endcase
        return res;
    endfunction

    function void note_request(fpfc_pkg::in_t req);
        pending_results.push_back(convert(req));
    endfunction

    function void check_result(fpfc_pkg::out_t got);
        fpfc_pkg::out_t want;
        if (pending_results.size() == 0) begin
            unexpected++;
            $display("Unexpected result transaction %h", got);
            return;
        end
        want = pending_results.pop_front();
        if (got.fixed_result !== want.fixed_result ||
            got.float_result_bits !== want.float_result_bits ||
            got.int_result !== want.int_result || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch: fixed %h/%h float %h/%h int %h/%h status %0d/%0d (exp/got)",
                         want.fixed_result, got.fixed_result, want.float_result_bits,
                         got.float_result_bits, want.int_result, got.int_result,
                         want.status, got.status);
        end
    endfunction
endclass

module fixed_point_format_converter_tb;
    import fpfc_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int unsigned send_idle_pct = 31;
    int unsigned recv_idle_pct = 72;
    bit          draining = 1'b0;

    conversion_scoreboard scoreboard = new();

    fixed_point_format_converter dut (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            scoreboard.check_result(m_data);
        m_ready <= draining ? 1'b1 : ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic idle_cycles(int unsigned n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_request(in_t req);
        while ($urandom_range(99) < send_idle_pct)
            idle_cycles(1);
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        scoreboard.note_request(req);
    endtask

    function automatic in_t random_request();
        in_t req;
        logic [7:0] ex;
        req.req_type = 2'($urandom_range(3));
        req.int_value = $urandom;
        req.float_bits = $urandom;
        req.fixed_value = $urandom;
        case ($urandom_range(3))
            0: req.int_value = int'($urandom_range(16777215)) - 8388608;
            1: begin
                ex = 8'($urandom_range(100, 152));
                req.float_bits[30:23] = ex;
            end
            default: ;
        endcase
        return req;
    endfunction

    task automatic send_op(req_type_t op, logic [31:0] operand);
        in_t req;
        req = '0;
        req.req_type = op;
        req.int_value = operand;
        req.float_bits = operand;
        req.fixed_value = operand;
        send_request(req);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_op(REQ_INT_TO_FIXED, 32'd8388607);
        send_op(REQ_INT_TO_FIXED, 32'hFF80_0000);
        send_op(REQ_INT_TO_FIXED, 32'd8388608);
        send_op(REQ_INT_TO_FIXED, 32'h8000_0000);
        send_op(REQ_FLOAT_TO_FIXED, 32'h7FC0_0000);
        send_op(REQ_FLOAT_TO_FIXED, 32'h7F80_0000);
        send_op(REQ_FLOAT_TO_FIXED, 32'hFF80_0000);
        send_op(REQ_FLOAT_TO_FIXED, 32'h8000_0000);
        send_op(REQ_FLOAT_TO_FIXED, 32'h0000_0001);
        send_op(REQ_FLOAT_TO_FIXED, 32'h4AFF_FFFE);
        send_op(REQ_FLOAT_TO_FIXED, 32'h4B00_0000);
        send_op(REQ_FLOAT_TO_FIXED, 32'hCB00_0000);
        send_op(REQ_FLOAT_TO_FIXED, 32'hCB00_0001);
        send_op(REQ_FLOAT_TO_FIXED, 32'h3B00_0000);
        send_op(REQ_FLOAT_TO_FIXED, 32'hBB40_0000);
        send_op(REQ_FIXED_TO_FLOAT, 32'h0000_0000);
        send_op(REQ_FIXED_TO_FLOAT, 32'h7FFF_FFFF);
        send_op(REQ_FIXED_TO_FLOAT, 32'h8000_0000);
        send_op(REQ_FIXED_TO_FLOAT, 32'h0100_0001);
        send_op(REQ_FIXED_TO_FLOAT, 32'h0100_0003);
        send_op(REQ_FIXED_TO_INT, 32'h7FFF_FFFF);
        send_op(REQ_FIXED_TO_INT, 32'h8000_0000);
        send_op(REQ_FIXED_TO_INT, 32'hFFFF_FFFF);
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 72;
                recv_idle_pct = 31;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 130; n++) begin
                send_request(random_request());
                if ($urandom_range(15) == 0)
                    idle_cycles($urandom_range(1, 6));
            end
        end
        s_valid <= 1'b0;
        draining = 1'b1;
        while (scoreboard.pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (scoreboard.mismatches == 0 && scoreboard.unexpected == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
